@@ hw/rtl/ycbcr_saturation_lightness_adjust_top_defines.svh @@
// Assertion macros for the YCbCr saturation/lightness adjust block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef YCBCR_SATURATION_LIGHTNESS_ADJUST_TOP_DEFINES_SVH
`define YCBCR_SATURATION_LIGHTNESS_ADJUST_TOP_DEFINES_SVH

// Checked only while out of reset
`define YSLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included
`define YSLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/ysla_pkg.sv @@
// Shared types and constants for the YCbCr saturation/lightness adjust block.
// No dependencies.
`default_nettype none

package ysla_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned FACTOR_W      = 12;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned TDATA_W       = 24;

  // Unity in Q4.8
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 12'd256;

  // Register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SAT  = 2'd0,
    REG_GAIN = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] sat;
    logic [FACTOR_W-1:0] gain;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/ysla_fwd.sv @@
// Forward RGB to YCbCr conversion stage (one register stage).
// Depends on ysla_pkg.
`default_nettype none

module ysla_fwd import ysla_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire pixel_t                      pix_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic        [FRAC_BITS+9:0]      y_o,
  output logic signed [FRAC_BITS+9:0]      dcb_o,
  output logic signed [FRAC_BITS+9:0]      dcr_o
);

  localparam int unsigned W = FRAC_BITS + 10;

  // Conversion constants, rounded to FRAC_BITS fraction bits
  localparam longint K_Y_R  = ((longint'(299)  << FRAC_BITS) + 500)  / 1000;
  localparam longint K_Y_G  = ((longint'(587)  << FRAC_BITS) + 500)  / 1000;
  localparam longint K_Y_B  = ((longint'(114)  << FRAC_BITS) + 500)  / 1000;
  localparam longint K_CB_R = ((longint'(1687) << FRAC_BITS) + 5000) / 10000;
  localparam longint K_CB_G = ((longint'(3313) << FRAC_BITS) + 5000) / 10000;
  localparam longint K_HALF = ((longint'(5)    << FRAC_BITS) + 5)    / 10;
  localparam longint K_CR_G = ((longint'(4187) << FRAC_BITS) + 5000) / 10000;
  localparam longint K_CR_B = ((longint'(813)  << FRAC_BITS) + 5000) / 10000;

  logic [W-1:0] r_w, g_w, b_w;
  logic [W-1:0] y_d, dcb_d, dcr_d;
  logic [W-1:0] y_q, dcb_q, dcr_q;
  logic         valid_q;

  assign r_w = W'(pix_i.red);
  assign g_w = W'(pix_i.green);
  assign b_w = W'(pix_i.blue);

  // Constant products; chroma kept as offset from mid scale (wraps as two's complement)
  always_comb begin
    y_d   = r_w * W'(K_Y_R) + g_w * W'(K_Y_G) + b_w * W'(K_Y_B);
    dcb_d = b_w * W'(K_HALF) - r_w * W'(K_CB_R) - g_w * W'(K_CB_G);
    dcr_d = r_w * W'(K_HALF) - g_w * W'(K_CR_G) - b_w * W'(K_CR_B);
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      y_q   <= y_d;
      dcb_q <= dcb_d;
      dcr_q <= dcr_d;
    end
  end

  assign valid_o = valid_q;
  assign y_o     = y_q;
  assign dcb_o   = $signed(dcb_q);
  assign dcr_o   = $signed(dcr_q);

endmodule

`default_nettype wire

@@ hw/rtl/ysla_adj.sv @@
// Lightness gain and saturation scaling: multiply stage, then round/clamp stage.
// Depends on ysla_pkg.
`default_nettype none

module ysla_adj import ysla_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cfg_t                        cfg_i,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic        [FRAC_BITS+9:0] y_i,
  input  wire logic signed [FRAC_BITS+9:0] dcb_i,
  input  wire logic signed [FRAC_BITS+9:0] dcr_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic        [FRAC_BITS+7:0]      y_o,
  output logic signed [FRAC_BITS+8:0]      dcb_o,
  output logic signed [FRAC_BITS+8:0]      dcr_o
);

  localparam int unsigned W  = FRAC_BITS + 10;
  localparam int unsigned PW = W + FACTOR_W + 1;
  localparam int unsigned YW = FRAC_BITS + 8;
  localparam int unsigned DW = FRAC_BITS + 9;
  localparam logic signed [PW-1:0] MID_P  = PW'(longint'(128) << FRAC_BITS);
  localparam logic signed [PW-1:0] TOP_P  = PW'(longint'(255) << FRAC_BITS);
  localparam logic signed [PW-1:0] HALF_P = PW'(128);

  // Stage B: factor multiplies
  logic signed [PW-1:0] yp_d, cbp_d, crp_d;
  logic signed [PW-1:0] yp_q, cbp_q, crp_q;
  logic                 mul_valid_q;
  logic                 mul_ready;
  logic signed [FACTOR_W:0] gain_s, sat_s;

  assign gain_s = $signed({1'b0, cfg_i.gain});
  assign sat_s  = $signed({1'b0, cfg_i.sat});

  always_comb begin
    yp_d  = PW'($signed({1'b0, y_i})) * PW'(gain_s);
    cbp_d = PW'(dcb_i) * PW'(sat_s);
    crp_d = PW'(dcr_i) * PW'(sat_s);
  end

  assign ready_o = ~mul_valid_q | mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (ready_o) begin
      mul_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      yp_q  <= yp_d;
      cbp_q <= cbp_d;
      crp_q <= crp_d;
    end
  end

  // Stage C: round half up by 8 bits, re-center chroma, clamp to 0..255
  function automatic logic signed [PW-1:0] clamp_p(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > TOP_P) begin
      res = TOP_P;
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic signed [PW-1:0] y_cl, cb_cl, cr_cl;
  logic [YW-1:0]        y_d, y_q;
  logic signed [DW-1:0] dcb_d, dcr_d, dcb_q, dcr_q;
  logic                 rnd_valid_q;

  always_comb begin
    y_cl  = clamp_p((yp_q + HALF_P) >>> 8);
    cb_cl = clamp_p(((cbp_q + HALF_P) >>> 8) + MID_P);
    cr_cl = clamp_p(((crp_q + HALF_P) >>> 8) + MID_P);
    y_d   = y_cl[YW-1:0];
    dcb_d = DW'(cb_cl - MID_P);
    dcr_d = DW'(cr_cl - MID_P);
  end

  assign mul_ready = ~rnd_valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
    end else if (mul_ready) begin
      rnd_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid_q && mul_ready) begin
      y_q   <= y_d;
      dcb_q <= dcb_d;
      dcr_q <= dcr_d;
    end
  end

  assign valid_o = rnd_valid_q;
  assign y_o     = y_q;
  assign dcb_o   = dcb_q;
  assign dcr_o   = dcr_q;

endmodule

`default_nettype wire

@@ hw/rtl/ysla_inv.sv @@
// Inverse YCbCr to RGB conversion: multiply stage, then sum/round/clamp output stage.
// Depends on ysla_pkg.
`default_nettype none

module ysla_inv import ysla_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic        [FRAC_BITS+7:0] y_i,
  input  wire logic signed [FRAC_BITS+8:0] dcb_i,
  input  wire logic signed [FRAC_BITS+8:0] dcr_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output pixel_t                           pix_o
);

  localparam int unsigned YW = FRAC_BITS + 8;
  localparam int unsigned QW = 2 * FRAC_BITS + 11;
  localparam int unsigned SW = FRAC_BITS + 11;

  localparam longint K_R_CR = ((longint'(1402)  << FRAC_BITS) + 500)   / 1000;
  localparam longint K_G_CR = ((longint'(71414) << FRAC_BITS) + 50000) / 100000;
  localparam longint K_G_CB = ((longint'(34414) << FRAC_BITS) + 50000) / 100000;
  localparam longint K_B_CB = ((longint'(1772)  << FRAC_BITS) + 500)   / 1000;

  localparam logic signed [QW-1:0] HALF_Q = QW'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] HALF_S = SW'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] TOP_S  = SW'(longint'(255) << FRAC_BITS);

  // Stage D: constant multiplies on the chroma offsets
  logic signed [QW-1:0] rcr_d, gcr_d, gcb_d, bcb_d;
  logic signed [QW-1:0] rcr_q, gcr_q, gcb_q, bcb_q;
  logic [YW-1:0]        y_q;
  logic                 mul_valid_q;
  logic                 out_ready;

  always_comb begin
    rcr_d = QW'(dcr_i) * QW'(K_R_CR);
    gcr_d = QW'(dcr_i) * QW'(K_G_CR);
    gcb_d = QW'(dcb_i) * QW'(K_G_CB);
    bcb_d = QW'(dcb_i) * QW'(K_B_CB);
  end

  assign ready_o = ~mul_valid_q | out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (ready_o) begin
      mul_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rcr_q <= rcr_d;
      gcr_q <= gcr_d;
      gcb_q <= gcb_d;
      bcb_q <= bcb_d;
      y_q   <= y_i;
    end
  end

  // Stage E: round terms, sum with luma, clamp and round to a byte
  function automatic logic signed [SW-1:0] rnd_term(input logic signed [QW-1:0] p);
    logic signed [QW-1:0] s;
    s = (p + HALF_Q) >>> FRAC_BITS;
    return SW'(s);
  endfunction

  function automatic logic [PIX_W-1:0] to_byte(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    logic signed [SW-1:0] r;
    if (v < 0) begin
      c = '0;
    end else if (v > TOP_S) begin
      c = TOP_S;
    end else begin
      c = v;
    end
    r = (c + HALF_S) >>> FRAC_BITS;
    return r[PIX_W-1:0];
  endfunction

  logic signed [SW-1:0] y_s, ro, go, bo;
  pixel_t               pix_d, pix_q;
  logic                 out_valid_q;

  always_comb begin
    y_s         = $signed({3'b000, y_q});
    ro          = y_s + rnd_term(rcr_q);
    go          = y_s - rnd_term(gcr_q) - rnd_term(gcb_q);
    bo          = y_s + rnd_term(bcb_q);
    pix_d.red   = to_byte(ro);
    pix_d.green = to_byte(go);
    pix_d.blue  = to_byte(bo);
  end

  assign out_ready = ~out_valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid_q && out_ready) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = out_valid_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire

@@ hw/rtl/ycbcr_saturation_lightness_adjust_top.sv @@
// Throughput: one pixel per cycle while the output is not stalled; every stage
// (forward convert, factor multiply, round/clamp, inverse multiply, output
// sum/round) has its own register and ready. A stalled output holds the last
// stage, then each full stage in front of it; upstream bubbles still close up.
// Reset (async, active low) empties the pipeline and sets both factors to 1.0 (256).
// Depends on ysla_pkg, ysla_fwd, ysla_adj, ysla_inv and the defines header.
`default_nettype none

`include "ycbcr_saturation_lightness_adjust_top_defines.svh"

module ycbcr_saturation_lightness_adjust_top import ysla_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Pixel input: tdata = red [7:0], green [15:8], blue [23:16]
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [TDATA_W-1:0]    s_axis_tdata_i,
  // Pixel output: tdata = red [7:0], green [15:8], blue [23:16]
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [TDATA_W-1:0]         m_axis_tdata_o,
  // Register writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [FACTOR_W-1:0]   cfg_data_i
);

  // Configuration registers
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sat  <= FACTOR_ONE;
      cfg_q.gain <= FACTOR_ONE;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_SAT:  cfg_q.sat  <= cfg_data_i;
        REG_GAIN: cfg_q.gain <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input unpacking
  pixel_t pix_in;

  assign pix_in.red   = s_axis_tdata_i[7:0];
  assign pix_in.green = s_axis_tdata_i[15:8];
  assign pix_in.blue  = s_axis_tdata_i[23:16];

  // Pipeline
  logic                        fwd_valid, fwd_ready;
  logic        [FRAC_BITS+9:0] fwd_y;
  logic signed [FRAC_BITS+9:0] fwd_dcb, fwd_dcr;
  logic                        adj_valid, adj_ready;
  logic        [FRAC_BITS+7:0] adj_y;
  logic signed [FRAC_BITS+8:0] adj_dcb, adj_dcr;
  pixel_t                      pix_out;

  ysla_fwd #(.FRAC_BITS(FRAC_BITS)) u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .pix_i   (pix_in),
    .valid_o (fwd_valid),
    .ready_i (fwd_ready),
    .y_o     (fwd_y),
    .dcb_o   (fwd_dcb),
    .dcr_o   (fwd_dcr)
  );

  ysla_adj #(.FRAC_BITS(FRAC_BITS)) u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (fwd_valid),
    .ready_o (fwd_ready),
    .y_i     (fwd_y),
    .dcb_i   (fwd_dcb),
    .dcr_i   (fwd_dcr),
    .valid_o (adj_valid),
    .ready_i (adj_ready),
    .y_o     (adj_y),
    .dcb_o   (adj_dcb),
    .dcr_o   (adj_dcr)
  );

  ysla_inv #(.FRAC_BITS(FRAC_BITS)) u_inv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (adj_valid),
    .ready_o (adj_ready),
    .y_i     (adj_y),
    .dcb_i   (adj_dcb),
    .dcr_i   (adj_dcr),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .pix_o   (pix_out)
  );

  assign m_axis_tdata_o = {pix_out.blue, pix_out.green, pix_out.red};

  // Checks
  `YSLA_ASSERT(a_no_backpressure_leak, m_axis_tready_i |-> s_axis_tready_o, "input stalled while output ready")
  `YSLA_ASSERT(a_sat_write, cfg_valid_i && (cfg_addr_i == REG_SAT) |=> cfg_q.sat == $past(cfg_data_i), "saturation write lost")
  `YSLA_ASSERT(a_gain_write, cfg_valid_i && (cfg_addr_i == REG_GAIN) |=> cfg_q.gain == $past(cfg_data_i), "gain write lost")
  `YSLA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "output valid right after reset")

endmodule

`default_nettype wire

@@ verif/ysla_adjust_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the YCbCr saturation/lightness adjust block: tracks register
// writes, predicts each output pixel and compares it. Depends on ysla_pkg.
module ysla_adjust_checker import ysla_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel input channel
  input  logic                  pix_in_valid_i,
  input  logic                  pix_in_ready_i,
  input  logic [TDATA_W-1:0]    pix_in_data_i,
  // Pixel output channel
  input  logic                  pix_out_valid_i,
  input  logic                  pix_out_ready_i,
  input  logic [TDATA_W-1:0]    pix_out_data_i,
  // Register write channel
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [FACTOR_W-1:0]   cfg_data_i,
  // Status toward the testbench top
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_count_o,
  output int unsigned           checked_count_o
);

  localparam int FB = FRAC_BITS_DEF;

  // Conversion constant rounded to FB fraction bits, halves up
  function automatic longint fx_const(input longint num, input longint den);
    return ((num << FB) + den / 2) / den;
  endfunction

  localparam longint K_Y_R  = fx_const(299, 1000);
  localparam longint K_Y_G  = fx_const(587, 1000);
  localparam longint K_Y_B  = fx_const(114, 1000);
  localparam longint K_CB_R = fx_const(1687, 10000);
  localparam longint K_CB_G = fx_const(3313, 10000);
  localparam longint K_HALF = fx_const(5, 10);
  localparam longint K_CR_G = fx_const(4187, 10000);
  localparam longint K_CR_B = fx_const(813, 10000);
  localparam longint K_R_CR = fx_const(1402, 1000);
  localparam longint K_G_CR = fx_const(71414, 100000);
  localparam longint K_G_CB = fx_const(34414, 100000);
  localparam longint K_B_CB = fx_const(1772, 1000);
  localparam longint MID_FX = longint'(128) << FB;
  localparam longint TOP_FX = longint'(255) << FB;

  logic [FACTOR_W-1:0] sat_q;
  logic [FACTOR_W-1:0] gain_q;
  pixel_t              expected_px[$];
  pixel_t              want_px;
  pixel_t              got_px;
  bit                  beat_bad;
  int unsigned         mismatches;
  int unsigned         checked;

  // Divide by 2^s, halves toward +inf (arithmetic shift floors)
  function automatic longint round_q(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_fx(input longint v);
    if (v < 0) return 0;
    if (v > TOP_FX) return TOP_FX;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] to_channel(input longint v);
    longint q;
    q = round_q(clamp_fx(v), FB);
    if (q > 255) q = 255;
    return q[PIX_W-1:0];
  endfunction

  // RGB -> YCbCr, gain on luma, factor on chroma, back to RGB
  function automatic pixel_t adjust_pixel(input pixel_t px,
                                          input logic [FACTOR_W-1:0] sat,
                                          input logic [FACTOR_W-1:0] gain);
    longint r, g, b, y, cb, cr, ro, go, bo;
    pixel_t res;
    r  = longint'(px.red);
    g  = longint'(px.green);
    b  = longint'(px.blue);
    y  = K_Y_R * r + K_Y_G * g + K_Y_B * b;
    cb = MID_FX - K_CB_R * r - K_CB_G * g + K_HALF * b;
    cr = MID_FX + K_HALF * r - K_CR_G * g - K_CR_B * b;
    // factors are Q4.8; chroma is clamped only after scaling
    y  = clamp_fx(round_q(y * longint'(gain), 8));
    cb = clamp_fx(round_q((cb - MID_FX) * longint'(sat), 8) + MID_FX) - MID_FX;
    cr = clamp_fx(round_q((cr - MID_FX) * longint'(sat), 8) + MID_FX) - MID_FX;
    ro = y + round_q(K_R_CR * cr, FB);
    go = y - round_q(K_G_CR * cr, FB) - round_q(K_G_CB * cb, FB);
    bo = y + round_q(K_B_CB * cb, FB);
    res.red   = to_channel(ro);
    res.green = to_channel(go);
    res.blue  = to_channel(bo);
    return res;
  endfunction

  task automatic check_channel(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
    if (got !== want) begin
      beat_bad = 1'b1;
      $display("%0t: pixel %0d %s mismatch, expected %0d, got %0d",
               $time, checked, name, want, got);
    end
  endtask

  // Track writes, queue predictions, compare output beats in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q            <= FACTOR_ONE;
      gain_q           <= FACTOR_ONE;
      expected_px.delete();
      mismatches        = 0;
      checked           = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
      checked_count_o  <= 0;
    end else begin
      if (pix_out_valid_i && pix_out_ready_i) begin
        got_px = pix_out_data_i;
        if (expected_px.size() == 0) begin
          $display("%0t: output beat with no pixel pending, expected none, got %h",
                   $time, got_px);
          mismatches++;
        end else begin
          want_px  = expected_px.pop_front();
          beat_bad = 1'b0;
          check_channel("red", want_px.red, got_px.red);
          check_channel("green", want_px.green, got_px.green);
          check_channel("blue", want_px.blue, got_px.blue);
          if (beat_bad) mismatches++;
          checked++;
        end
      end
      if (pix_in_valid_i && pix_in_ready_i)
        expected_px.push_back(adjust_pixel(pix_in_data_i, sat_q, gain_q));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          REG_SAT:  sat_q  <= cfg_data_i;
          REG_GAIN: gain_q <= cfg_data_i;
          default: ;  // unmapped index, write dropped
        endcase
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_px.size();
      checked_count_o  <= checked;
    end
  end

endmodule

@@ verif/tb_ycbcr_saturation_lightness_adjust_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the YCbCr saturation/lightness adjust block: clock, reset,
// pixel and register stimulus, verdict. Depends on ysla_pkg and ysla_adjust_checker.
module tb_ycbcr_saturation_lightness_adjust_top;
  import ysla_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int RAND_PHASES    = 12;
  localparam int PIX_PER_PHASE  = 100;
  localparam int QUIET_PHASES   = 2;   // tail of the run with no idling
  localparam int DRAIN_LIMIT    = 5000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [TDATA_W-1:0]    s_axis_tdata_i;   // red [7:0], green [15:8], blue [23:16]
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [TDATA_W-1:0]    m_axis_tdata_o;   // red [7:0], green [15:8], blue [23:16]
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [FACTOR_W-1:0]   cfg_data_i;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned pixels_sent;
  int unsigned settings_used;
  bit          idle_on;

  ycbcr_saturation_lightness_adjust_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  ysla_adjust_checker u_adjust_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pix_in_valid_i   (s_axis_tvalid_i),
    .pix_in_ready_i   (s_axis_tready_o),
    .pix_in_data_i    (s_axis_tdata_i),
    .pix_out_valid_i  (m_axis_tvalid_o),
    .pix_out_ready_i  (m_axis_tready_i),
    .pix_out_data_i   (m_axis_tdata_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout: %0d pixels sent, %0d checked", pixels_sent, checked_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // Output back-pressure: random stall bursts while idling is on
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // One pixel beat, optionally preceded by an idle burst
  task automatic push_pixel(input pixel_t px);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Stop input and wait for every predicted pixel to come out
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Back-to-back register writes, valid held high across them
  task automatic load_factors(input logic [FACTOR_W-1:0] sat,
                              input logic [FACTOR_W-1:0] gain, input bit poke_spare);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= REG_SAT;
    cfg_data_i  <= sat;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_addr_i <= REG_GAIN;
    cfg_data_i <= gain;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (poke_spare) begin
      cfg_addr_i <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
      cfg_data_i <= FACTOR_W'($urandom_range(0, 4095));
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Corner pixels: black, white, primaries, alternating bit pattern
  task automatic push_corner_pixels();
    push_pixel({8'h00, 8'h00, 8'h00});
    push_pixel({8'hFF, 8'hFF, 8'hFF});
    push_pixel({8'h00, 8'h00, 8'hFF});
    push_pixel({8'h00, 8'hFF, 8'h00});
    push_pixel({8'hFF, 8'h00, 8'h00});
    push_pixel({8'h55, 8'hAA, 8'h55});
  endtask

  function automatic logic [FACTOR_W-1:0] pick_factor();
    case ($urandom_range(0, 4))
      0:       return FACTOR_ONE;
      1:       return $urandom_range(0, 1) ? {FACTOR_W{1'b1}} : {FACTOR_W{1'b0}};
      2:       return FACTOR_W'($urandom_range(128, 512));
      default: return FACTOR_W'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    pixel_t px;
    int     guard;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_addr_i      = REG_SAT;
    cfg_data_i      = '0;
    idle_on         = 1'b1;
    pixels_sent     = 0;
    settings_used   = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset factors, both at maximum, both at zero, a high-saturation, low-gain pair
    push_corner_pixels();
    drain();
    load_factors({FACTOR_W{1'b1}}, {FACTOR_W{1'b1}}, 1'b1);
    push_corner_pixels();
    drain();
    load_factors('0, '0, 1'b0);
    push_corner_pixels();
    drain();
    load_factors(12'd2048, 12'd128, 1'b1);
    push_corner_pixels();

    // Random: a new factor pair per phase, idling off in the middle phase and at the end
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      idle_on = (p < RAND_PHASES - QUIET_PHASES) && (p != RAND_PHASES / 2);
      load_factors(pick_factor(), pick_factor(), $urandom_range(0, 3) == 0);
      for (int i = 0; i < PIX_PER_PHASE; i++) begin
        px = TDATA_W'($urandom_range(0, 24'hFF_FFFF));
        if ($urandom_range(0, 9) == 0) px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 9) == 0) px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 9) == 0) px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        push_pixel(px);
      end
    end

    // Let the pipeline empty, then wait on for stray beats
    s_axis_tvalid_i <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending_count != 0 && guard < DRAIN_LIMIT);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d of %0d pixels over %0d factor settings (0 to 4095, unmapped writes).",
             checked_count, pixels_sent, settings_used);
    $display("Beats in error: %0d, still pending: %0d", mismatch_count, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ysla_pkg.sv
hw/rtl/ysla_fwd.sv
hw/rtl/ysla_adj.sv
hw/rtl/ysla_inv.sv
hw/rtl/ycbcr_saturation_lightness_adjust_top.sv
verif/ysla_adjust_checker.sv
verif/tb_ycbcr_saturation_lightness_adjust_top.sv
